// ===== src/tk_pkg.sv =====
// ----------------------------------------------------------------------------
// tk_pkg: clock tick timekeeper shared types and constants
// Field widths, register indexes, reset values and the beat structs that
// travel between the timekeeper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tk_pkg;

   // field widths
   localparam int INC_W      = 24;
   localparam int LEVEL_W    = 5;
   localparam int TOTAL_W    = 32;
   localparam int DEPTH_W    = 8;
   localparam int QUANT_W    = 8;
   localparam int TIME_W     = 64;
   localparam int CNT_W      = 32;
   localparam int HAND_W     = 8;
   localparam int STEP_W     = 4;
   localparam int OFFSET_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // interrupt level at which deferred routines run
   localparam logic [LEVEL_W-1:0] DEFER_LEVEL = 5'd2;

   // register reset values
   localparam logic [INC_W-1:0]   RST_MAX_INCREMENT    = 24'd100000;
   localparam logic [INC_W-1:0]   RST_TIME_ADJUSTMENT  = 24'd100000;
   localparam logic [DEPTH_W-1:0] RST_ADJUST_THRESHOLD = 8'd20;
   localparam logic [DEPTH_W-1:0] RST_IDEAL_DPC_RATE   = 8'd20;
   localparam logic [DEPTH_W-1:0] RST_DEPTH_CEILING    = 8'd4;
   localparam logic [STEP_W-1:0]  RST_QUANTUM_STEP     = 4'd3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_INCREMENT    = 3'd0,
      CSR_TIME_ADJUSTMENT  = 3'd1,
      CSR_ADJUST_THRESHOLD = 3'd2,
      CSR_IDEAL_DPC_RATE   = 3'd3,
      CSR_DEPTH_CEILING    = 3'd4,
      CSR_QUANTUM_STEP     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [INC_W-1:0]   max_increment;
      logic [INC_W-1:0]   time_adjustment;
      logic [DEPTH_W-1:0] adjust_threshold;
      logic [DEPTH_W-1:0] ideal_dpc_rate;
      logic [DEPTH_W-1:0] depth_ceiling;
      logic [STEP_W-1:0]  quantum_step;
   } cfg_type;

   typedef struct packed {
      logic                      skip_tick;
      logic [INC_W-1:0]          increment;
      logic [LEVEL_W-1:0]        old_level;
      logic                      dpc_active;
      logic [TOTAL_W-1:0]        dpc_total;
      logic [DEPTH_W-1:0]        queue_depth;
      logic signed [QUANT_W-1:0] thread_quantum;
      logic                      is_idle;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]         interrupt_time;
      logic [TIME_W-1:0]         system_time;
      logic [TIME_W-1:0]         tick_total;
      logic [HAND_W-1:0]         timer_hand;
      logic                      full_tick;
      logic                      kernel_tick;
      logic signed [QUANT_W-1:0] new_quantum;
      logic                      quantum_end;
      logic                      request_dispatch;
      logic [DEPTH_W-1:0]        max_depth;
      logic [CNT_W-1:0]          request_rate;
      logic                      skipped;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/tk_ifs.sv =====
// ----------------------------------------------------------------------------
// tk_ifs: timekeeper channel interfaces
// Valid/ready channels for tick beats, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tk_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     skip_tick;
   logic [tk_pkg::INC_W-1:0]                 increment;
   logic [tk_pkg::LEVEL_W-1:0]               old_level;
   logic                                     dpc_active;
   logic [tk_pkg::TOTAL_W-1:0]               dpc_total;
   logic [tk_pkg::DEPTH_W-1:0]               queue_depth;
   logic signed [tk_pkg::QUANT_W-1:0]        thread_quantum;
   logic                                     is_idle;

   modport source (output valid, skip_tick, increment, old_level, dpc_active,
                   dpc_total, queue_depth, thread_quantum, is_idle,
                   input ready);
   modport sink (input valid, skip_tick, increment, old_level, dpc_active,
                 dpc_total, queue_depth, thread_quantum, is_idle,
                 output ready);
endinterface

interface tk_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [tk_pkg::TIME_W-1:0]                interrupt_time;
   logic [tk_pkg::TIME_W-1:0]                system_time;
   logic [tk_pkg::TIME_W-1:0]                tick_total;
   logic [tk_pkg::HAND_W-1:0]                timer_hand;
   logic                                     full_tick;
   logic                                     kernel_tick;
   logic signed [tk_pkg::QUANT_W-1:0]        new_quantum;
   logic                                     quantum_end;
   logic                                     request_dispatch;
   logic [tk_pkg::DEPTH_W-1:0]               max_depth;
   logic [tk_pkg::CNT_W-1:0]                 request_rate;
   logic                                     skipped;

   modport source (output valid, interrupt_time, system_time, tick_total,
                   timer_hand, full_tick, kernel_tick, new_quantum, quantum_end,
                   request_dispatch, max_depth, request_rate, skipped,
                   input ready);
   modport sink (input valid, interrupt_time, system_time, tick_total,
                 timer_hand, full_tick, kernel_tick, new_quantum, quantum_end,
                 request_dispatch, max_depth, request_rate, skipped,
                 output ready);
endinterface

interface tk_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [tk_pkg::CSR_IDX_W-1:0]             index;
   logic [tk_pkg::CSR_DATA_W-1:0]            data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/tk_csr.sv =====
// ----------------------------------------------------------------------------
// tk_csr: timekeeper configuration registers
// Holds the six tuning registers, written one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tk_csr (
   input  logic            clock,
   input  logic            reset,
   tk_csr_if.sink          csr_chan,
   output tk_pkg::cfg_type cfg
);
   import tk_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    csr_write;

   // writes are always taken
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   // decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_chan.index))
            CSR_MAX_INCREMENT:    cfg_in.max_increment    = csr_chan.data;
            CSR_TIME_ADJUSTMENT:  cfg_in.time_adjustment  = csr_chan.data;
            CSR_ADJUST_THRESHOLD: cfg_in.adjust_threshold = csr_chan.data[DEPTH_W-1:0];
            CSR_IDEAL_DPC_RATE:   cfg_in.ideal_dpc_rate   = csr_chan.data[DEPTH_W-1:0];
            CSR_DEPTH_CEILING:    cfg_in.depth_ceiling    = csr_chan.data[DEPTH_W-1:0];
            CSR_QUANTUM_STEP:     cfg_in.quantum_step     = csr_chan.data[STEP_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_increment    <= RST_MAX_INCREMENT;
         cfg_ff.time_adjustment  <= RST_TIME_ADJUSTMENT;
         cfg_ff.adjust_threshold <= RST_ADJUST_THRESHOLD;
         cfg_ff.ideal_dpc_rate   <= RST_IDEAL_DPC_RATE;
         cfg_ff.depth_ceiling    <= RST_DEPTH_CEILING;
         cfg_ff.quantum_step     <= RST_QUANTUM_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/tk_core.sv =====
// ----------------------------------------------------------------------------
// tk_core: timekeeper state and tick accounting
// Holds the time, offset and accounting registers and, while step is high,
// works out one tick beat per cycle from the registered beat and current state.
// ----------------------------------------------------------------------------
`default_nettype none

module tk_core #(
   parameter int TABLE_SIZE = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  tk_pkg::cfg_type cfg,
   input  tk_pkg::req_type item,
   output tk_pkg::rsp_type result
);
   import tk_pkg::*;

   localparam int IDX_W = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
   localparam logic [IDX_W-1:0] HAND_LAST = IDX_W'(TABLE_SIZE - 1);

   logic [TIME_W-1:0]   int_time_ff, int_time_in;
   logic [TIME_W-1:0]   sys_time_ff, sys_time_in;
   logic [TIME_W-1:0]   tick_count_ff, tick_count_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [CNT_W-1:0]    intr_count_ff, intr_count_in;
   logic [CNT_W-1:0]    isr_ticks_ff, isr_ticks_in;
   logic [CNT_W-1:0]    dpc_ticks_ff, dpc_ticks_in;
   logic [CNT_W-1:0]    rate_avg_ff, rate_avg_in;
   logic [CNT_W-1:0]    last_total_ff, last_total_in;
   logic [DEPTH_W-1:0]  countdown_ff, countdown_in;
   logic [DEPTH_W-1:0]  depth_limit_ff, depth_limit_in;
   logic [IDX_W-1:0]    hand_ff, hand_in;

   logic [OFFSET_W:0]   offset_diff;
   logic [OFFSET_W-1:0] offset_sat;
   logic                full;
   logic                ktick;
   logic                req_disp;
   logic [CNT_W-1:0]    new_requests;
   logic [CNT_W:0]      rate_sum;
   logic [CNT_W-1:0]    rate_new;
   logic [DEPTH_W-1:0]  countdown_dec;
   logic [QUANT_W:0]    quant_diff;
   logic [QUANT_W-1:0]  quant_new;
   logic                qend;
   logic [IDX_W+HAND_W-1:0] hand_wide;

   // offset subtract with saturation at the most negative value
   always_comb begin
      offset_diff = {offset_ff[OFFSET_W-1], offset_ff}
                  - {{(OFFSET_W-INC_W+1){1'b0}}, item.increment};
      if (offset_diff[OFFSET_W] && !offset_diff[OFFSET_W-1]) begin
         offset_sat = {1'b1, {(OFFSET_W-1){1'b0}}};
      end else begin
         offset_sat = offset_diff[OFFSET_W-1:0];
      end
      full = !item.skip_tick && (offset_sat[OFFSET_W-1] || offset_sat == '0);
   end

   // request rate average over the full 33-bit sum
   always_comb begin
      new_requests = item.dpc_total - last_total_ff;
      rate_sum     = {1'b0, new_requests} + {1'b0, rate_avg_ff};
      rate_new     = rate_sum[CNT_W:1];
   end

   // quantum decrement, saturating at the most negative value
   always_comb begin
      quant_diff = {item.thread_quantum[QUANT_W-1], item.thread_quantum}
                 - {{(QUANT_W-STEP_W+1){1'b0}}, cfg.quantum_step};
      if (quant_diff[QUANT_W] && !quant_diff[QUANT_W-1]) begin
         quant_new = {1'b1, {(QUANT_W-1){1'b0}}};
      end else begin
         quant_new = quant_diff[QUANT_W-1:0];
      end
   end

   assign countdown_dec = countdown_ff - 8'd1;

   // next state for one tick beat
   always_comb begin
      int_time_in    = int_time_ff;
      sys_time_in    = sys_time_ff;
      tick_count_in  = tick_count_ff;
      offset_in      = offset_ff;
      intr_count_in  = intr_count_ff;
      isr_ticks_in   = isr_ticks_ff;
      dpc_ticks_in   = dpc_ticks_ff;
      rate_avg_in    = rate_avg_ff;
      last_total_in  = last_total_ff;
      countdown_in   = countdown_ff;
      depth_limit_in = depth_limit_ff;
      hand_in        = hand_ff;
      ktick          = 1'b0;
      req_disp       = 1'b0;
      qend           = 1'b0;
      if (!item.skip_tick) begin
         int_time_in   = int_time_ff + {{(TIME_W-INC_W){1'b0}}, item.increment};
         offset_in     = offset_sat;
         intr_count_in = intr_count_ff + 32'd1;
      end
      if (full) begin
         sys_time_in   = sys_time_ff + {{(TIME_W-INC_W){1'b0}}, cfg.time_adjustment};
         tick_count_in = tick_count_ff + 64'd1;
         offset_in     = offset_sat + {{(OFFSET_W-INC_W){1'b0}}, cfg.max_increment};
         hand_in       = (hand_ff == HAND_LAST) ? '0 : hand_ff + IDX_W'(1);

         // split the tick by interrupted level
         if (item.old_level > DEFER_LEVEL) begin
            isr_ticks_in = isr_ticks_ff + 32'd1;
         end else if (item.old_level < DEFER_LEVEL || !item.dpc_active) begin
            ktick = 1'b1;
         end else begin
            dpc_ticks_in = dpc_ticks_ff + 32'd1;
         end

         rate_avg_in   = rate_new;
         last_total_in = item.dpc_total;

         // queue depth tuning
         if (item.queue_depth != '0 && !item.dpc_active) begin
            countdown_in = cfg.adjust_threshold;
            req_disp     = 1'b1;
            if (rate_new < {{(CNT_W-DEPTH_W){1'b0}}, cfg.ideal_dpc_rate}
                  && depth_limit_ff > 8'd1) begin
               depth_limit_in = depth_limit_ff - 8'd1;
            end
         end else begin
            countdown_in = countdown_dec;
            if (countdown_dec == '0) begin
               countdown_in = cfg.adjust_threshold;
               if (depth_limit_ff < cfg.depth_ceiling) begin
                  depth_limit_in = depth_limit_ff + 8'd1;
               end
            end
         end

         qend = (quant_new[QUANT_W-1] || quant_new == '0) && !item.is_idle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_time_ff    <= '0;
         sys_time_ff    <= '0;
         tick_count_ff  <= '0;
         offset_ff      <= {{(OFFSET_W-INC_W){1'b0}}, RST_MAX_INCREMENT};
         intr_count_ff  <= '0;
         isr_ticks_ff   <= '0;
         dpc_ticks_ff   <= '0;
         rate_avg_ff    <= '0;
         last_total_ff  <= '0;
         countdown_ff   <= RST_ADJUST_THRESHOLD;
         depth_limit_ff <= RST_DEPTH_CEILING;
         hand_ff        <= '0;
      end else if (step) begin
         int_time_ff    <= int_time_in;
         sys_time_ff    <= sys_time_in;
         tick_count_ff  <= tick_count_in;
         offset_ff      <= offset_in;
         intr_count_ff  <= intr_count_in;
         isr_ticks_ff   <= isr_ticks_in;
         dpc_ticks_ff   <= dpc_ticks_in;
         rate_avg_ff    <= rate_avg_in;
         last_total_ff  <= last_total_in;
         countdown_ff   <= countdown_in;
         depth_limit_ff <= depth_limit_in;
         hand_ff        <= hand_in;
      end
   end

   // result beat shows the state after this tick
   assign hand_wide = {{HAND_W{1'b0}}, hand_in};

   always_comb begin
      result.interrupt_time   = int_time_in;
      result.system_time      = sys_time_in;
      result.tick_total       = tick_count_in;
      result.timer_hand       = hand_wide[HAND_W-1:0];
      result.full_tick        = full;
      result.kernel_tick      = ktick;
      result.new_quantum      = full ? quant_new : item.thread_quantum;
      result.quantum_end      = qend;
      result.request_dispatch = req_disp;
      result.max_depth        = depth_limit_in;
      result.request_rate     = rate_avg_in;
      result.skipped          = item.skip_tick;
   end

endmodule

`default_nettype wire

// ===== src/clock_tick_timekeeper.sv =====
// A tick beat passes the input register and then the result register.
// Throughput: one tick beat per cycle while the result slot is free; each beat's
// add/compare pass in tk_core is combinational, so beats may follow back to back.
// Reset: synchronous, active high; clears the pipeline, times and counters
// and loads the registers and offset/countdown/depth limit with their defaults.
// ----------------------------------------------------------------------------
// clock_tick_timekeeper: clock interrupt time and run-time accounting
// Input beat register, tick accounting core and output result register,
// with a separate register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_tick_timekeeper #(
   parameter int TABLE_SIZE = 256
) (
   input  logic      clock,
   input  logic      reset,
   tk_req_if.sink    req_chan,
   tk_rsp_if.source  rsp_chan,
   tk_csr_if.sink    csr_chan
);
   import tk_pkg::*;

   cfg_type cfg;
   req_type req_beat;
   req_type in_data_ff, in_data_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type core_rsp;
   rsp_type out_data_ff, out_data_in;
   logic    out_valid_ff, out_valid_in;
   logic    out_free;
   logic    step;
   logic    req_take;

   tk_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // handshake: the input register moves on whenever the result slot frees
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || step;
   assign req_take       = req_chan.valid && req_chan.ready;

   // collect the input beat
   always_comb begin
      req_beat.skip_tick      = req_chan.skip_tick;
      req_beat.increment      = req_chan.increment;
      req_beat.old_level      = req_chan.old_level;
      req_beat.dpc_active     = req_chan.dpc_active;
      req_beat.dpc_total      = req_chan.dpc_total;
      req_beat.queue_depth    = req_chan.queue_depth;
      req_beat.thread_quantum = req_chan.thread_quantum;
      req_beat.is_idle        = req_chan.is_idle;
   end

   // input register
   always_comb begin
      in_data_in  = req_take ? req_beat : in_data_ff;
      in_valid_in = req_take || (in_valid_ff && !step);
   end

   tk_core #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .item   (in_data_ff),
      .result (core_rsp)
   );

   // result register
   always_comb begin
      out_data_in  = step ? core_rsp : out_data_ff;
      out_valid_in = step || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   // drive the result channel
   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.interrupt_time   = out_data_ff.interrupt_time;
   assign rsp_chan.system_time      = out_data_ff.system_time;
   assign rsp_chan.tick_total       = out_data_ff.tick_total;
   assign rsp_chan.timer_hand       = out_data_ff.timer_hand;
   assign rsp_chan.full_tick        = out_data_ff.full_tick;
   assign rsp_chan.kernel_tick      = out_data_ff.kernel_tick;
   assign rsp_chan.new_quantum      = out_data_ff.new_quantum;
   assign rsp_chan.quantum_end      = out_data_ff.quantum_end;
   assign rsp_chan.request_dispatch = out_data_ff.request_dispatch;
   assign rsp_chan.max_depth        = out_data_ff.max_depth;
   assign rsp_chan.request_rate     = out_data_ff.request_rate;
   assign rsp_chan.skipped          = out_data_ff.skipped;

endmodule

`default_nettype wire

// ===== tb/tk_tick_checker.sv =====
// ----------------------------------------------------------------------------
// tk_tick_checker: timekeeper result checker
// Watches the tick, result and register write channels, keeps its own copy
// of the timekeeper registers and state, predicts the result of every
// accepted tick beat and compares each result beat against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tk_tick_checker #(
   parameter int TABLE_SIZE = 256
) (
   input  logic clock,
   input  logic reset,
   tk_req_if    req_mon,
   tk_rsp_if    rsp_mon,
   tk_csr_if    csr_mon,
   output int   error_count,
   output int   pending_count
);
   import tk_pkg::*;

   localparam longint OFFSET_FLOOR = -64'sd2147483648;
   localparam int     QUANT_FLOOR  = -(2 ** (QUANT_W - 1));

   // register copy and timekeeping state
   cfg_type                    regs;
   logic [TIME_W-1:0]          irq_time;
   logic [TIME_W-1:0]          wall_time;
   logic [TIME_W-1:0]          full_ticks;
   logic signed [OFFSET_W-1:0] offset_left;
   logic [CNT_W-1:0]           dpc_rate;
   logic [CNT_W-1:0]           dpc_seen;
   logic [DEPTH_W-1:0]         grow_countdown;
   logic [DEPTH_W-1:0]         depth_cap;

   // results owed by the block, oldest first
   rsp_type                    owed_results[$];
   int                         mismatches;

   // advance the timekeeper by one interrupt and build the result it owes
   function automatic rsp_type account_tick(req_type t);
      rsp_type        r;
      longint         left;
      logic [CNT_W:0] rate_sum;
      int             quantum;
      r = '0;
      r.new_quantum = t.thread_quantum;
      r.skipped = t.skip_tick;
      if (!t.skip_tick) begin
         irq_time = irq_time + TIME_W'(t.increment);
         left = longint'(offset_left) - longint'(t.increment);
         if (left < OFFSET_FLOOR) begin
            left = OFFSET_FLOOR;
         end
         if (left <= 0) begin
            r.full_tick = 1'b1;
            wall_time = wall_time + TIME_W'(regs.time_adjustment);
            full_ticks = full_ticks + TIME_W'(1);
            left = left + longint'(regs.max_increment);

            // kernel time below the deferred level, or at it outside a dpc
            r.kernel_tick = (t.old_level < DEFER_LEVEL) ||
                            (t.old_level == DEFER_LEVEL && !t.dpc_active);

            // smoothed request rate, halved at 33 bits
            rate_sum = {1'b0, t.dpc_total - dpc_seen} + {1'b0, dpc_rate};
            dpc_rate = rate_sum[CNT_W:1];
            dpc_seen = t.dpc_total;

            // queue depth tuning
            if (t.queue_depth != '0 && !t.dpc_active) begin
               r.request_dispatch = 1'b1;
               grow_countdown = regs.adjust_threshold;
               if (dpc_rate < CNT_W'(regs.ideal_dpc_rate) && depth_cap > DEPTH_W'(1)) begin
                  depth_cap = depth_cap - DEPTH_W'(1);
               end
            end else begin
               grow_countdown = grow_countdown - DEPTH_W'(1);
               if (grow_countdown == '0) begin
                  grow_countdown = regs.adjust_threshold;
                  if (depth_cap < regs.depth_ceiling) begin
                     depth_cap = depth_cap + DEPTH_W'(1);
                  end
               end
            end

            // quantum decrement, saturating
            quantum = int'($signed(t.thread_quantum)) - int'(regs.quantum_step);
            if (quantum < QUANT_FLOOR) begin
               quantum = QUANT_FLOOR;
            end
            r.new_quantum = quantum[QUANT_W-1:0];
            r.quantum_end = (quantum <= 0) && !t.is_idle;
         end
         offset_left = left[OFFSET_W-1:0];
      end
      r.interrupt_time = irq_time;
      r.system_time = wall_time;
      r.tick_total = full_ticks;
      r.timer_hand = HAND_W'(full_ticks % TABLE_SIZE);
      r.max_depth = depth_cap;
      r.request_rate = dpc_rate;
      return r;
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   // follow the channels at every clock edge
   always @(posedge clock) begin : tracker
      rsp_type want;
      req_type seen;
      if (reset) begin
         regs.max_increment    = RST_MAX_INCREMENT;
         regs.time_adjustment  = RST_TIME_ADJUSTMENT;
         regs.adjust_threshold = RST_ADJUST_THRESHOLD;
         regs.ideal_dpc_rate   = RST_IDEAL_DPC_RATE;
         regs.depth_ceiling    = RST_DEPTH_CEILING;
         regs.quantum_step     = RST_QUANTUM_STEP;
         irq_time       = '0;
         wall_time      = '0;
         full_ticks     = '0;
         offset_left    = {{(OFFSET_W - INC_W){1'b0}}, RST_MAX_INCREMENT};
         dpc_rate       = '0;
         dpc_seen       = '0;
         grow_countdown = RST_ADJUST_THRESHOLD;
         depth_cap      = RST_DEPTH_CEILING;
         owed_results.delete();
         mismatches = 0;
      end else begin
         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_MAX_INCREMENT:    regs.max_increment = csr_mon.data;
               CSR_TIME_ADJUSTMENT:  regs.time_adjustment = csr_mon.data;
               CSR_ADJUST_THRESHOLD: regs.adjust_threshold = csr_mon.data[DEPTH_W-1:0];
               CSR_IDEAL_DPC_RATE:   regs.ideal_dpc_rate = csr_mon.data[DEPTH_W-1:0];
               CSR_DEPTH_CEILING:    regs.depth_ceiling = csr_mon.data[DEPTH_W-1:0];
               CSR_QUANTUM_STEP:     regs.quantum_step = csr_mon.data[STEP_W-1:0];
               default: ;
            endcase
         end

         // result beats against the oldest owed result
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with no tick outstanding", $time);
            end else begin
               want = owed_results.pop_front();
               check_field("interrupt_time", want.interrupt_time, rsp_mon.interrupt_time);
               check_field("system_time", want.system_time, rsp_mon.system_time);
               check_field("tick_total", want.tick_total, rsp_mon.tick_total);
               check_field("timer_hand", want.timer_hand, rsp_mon.timer_hand);
               check_field("full_tick", want.full_tick, rsp_mon.full_tick);
               check_field("kernel_tick", want.kernel_tick, rsp_mon.kernel_tick);
               check_field("new_quantum", $unsigned(want.new_quantum),
                           $unsigned(rsp_mon.new_quantum));
               check_field("quantum_end", want.quantum_end, rsp_mon.quantum_end);
               check_field("request_dispatch", want.request_dispatch,
                           rsp_mon.request_dispatch);
               check_field("max_depth", want.max_depth, rsp_mon.max_depth);
               check_field("request_rate", want.request_rate, rsp_mon.request_rate);
               check_field("skipped", want.skipped, rsp_mon.skipped);
            end
         end

         // tick beats
         if (req_mon.valid && req_mon.ready) begin
            seen.skip_tick      = req_mon.skip_tick;
            seen.increment      = req_mon.increment;
            seen.old_level      = req_mon.old_level;
            seen.dpc_active     = req_mon.dpc_active;
            seen.dpc_total      = req_mon.dpc_total;
            seen.queue_depth    = req_mon.queue_depth;
            seen.thread_quantum = req_mon.thread_quantum;
            seen.is_idle        = req_mon.is_idle;
            owed_results.push_back(account_tick(seen));
         end
      end
      error_count <= mismatches;
      pending_count <= owed_results.size();
   end

endmodule

`default_nettype wire

// ===== tb/clock_tick_timekeeper_tb.sv =====
// ----------------------------------------------------------------------------
// clock_tick_timekeeper_tb: timekeeper testbench top
// Drives tick beats and register writes into the timekeeper, paces the
// result channel with random stalls and one long hold-off, and reports the
// verdict from the checker's mismatch count. A short directed sequence is
// followed by random ticks over several register settings, the extremes
// among them, including a run that drives the tick offset into saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_tick_timekeeper_tb;
   import tk_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 4;
   localparam int HAND_TABLE      = 256;
   localparam int PHASES          = 8;
   localparam int TICKS_PER_PHASE = 148;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int CFG_BITS        = $bits(cfg_type);

   logic clock;
   logic reset;

   tk_req_if req_chan ();
   tk_rsp_if rsp_chan ();
   tk_csr_if csr_chan ();

   int                 error_count;
   int                 pending_count;
   cfg_type            active_cfg;
   logic [TOTAL_W-1:0] dpc_running;
   bit                 steady;
   bit                 big_steps;
   int                 hold_requests;

   clock_tick_timekeeper #(.TABLE_SIZE(HAND_TABLE)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   tk_tick_checker #(.TABLE_SIZE(HAND_TABLE)) tick_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // clock
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type make_tick(bit skip, logic [INC_W-1:0] inc,
                                         logic [LEVEL_W-1:0] level, bit active,
                                         logic [TOTAL_W-1:0] total,
                                         logic [DEPTH_W-1:0] depth,
                                         logic signed [QUANT_W-1:0] quantum, bit idle);
      req_type t;
      t.skip_tick      = skip;
      t.increment      = inc;
      t.old_level      = level;
      t.dpc_active     = active;
      t.dpc_total      = total;
      t.queue_depth    = depth;
      t.thread_quantum = quantum;
      t.is_idle        = idle;
      return t;
   endfunction

   // random interrupt, increments shaped around the current reload value
   function automatic req_type random_tick();
      req_type t;
      int      roll;
      t.skip_tick = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 9);
      if (big_steps || roll == 1) begin
         t.increment = '1;
      end else if (roll == 0) begin
         t.increment = '0;
      end else if (roll <= 4) begin
         t.increment = INC_W'($urandom_range(0, 255));
      end else if (roll <= 8) begin
         t.increment = INC_W'($urandom_range(0, active_cfg.max_increment));
      end else begin
         t.increment = INC_W'($urandom);
      end
      t.old_level = ($urandom_range(0, 9) < 8) ? LEVEL_W'($urandom_range(0, 3))
                                               : LEVEL_W'($urandom);
      t.dpc_active = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         dpc_running = $urandom;
      end else begin
         dpc_running = dpc_running + $urandom_range(0, 40);
      end
      t.dpc_total = dpc_running;
      t.queue_depth = $urandom_range(0, 1) ? DEPTH_W'($urandom) : '0;
      t.thread_quantum = QUANT_W'($urandom);
      t.is_idle = ($urandom_range(0, 4) == 0);
      return t;
   endfunction

   // offer one tick beat and hold it until accepted
   task automatic offer_tick(req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.skip_tick      <= t.skip_tick;
      req_chan.increment      <= t.increment;
      req_chan.old_level      <= t.old_level;
      req_chan.dpc_active     <= t.dpc_active;
      req_chan.dpc_total      <= t.dpc_total;
      req_chan.queue_depth    <= t.queue_depth;
      req_chan.thread_quantum <= t.thread_quantum;
      req_chan.is_idle        <= t.is_idle;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] word);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= word;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // write every register; narrow ones get random upper data bits
   task automatic program_settings(cfg_type c, bit unused_too);
      csr_index_type        idx;
      logic [CSR_DATA_W-1:0] word;
      idx = idx.first();
      repeat (idx.num()) begin
         word = CSR_DATA_W'($urandom);
         case (idx)
            CSR_MAX_INCREMENT:    word = c.max_increment;
            CSR_TIME_ADJUSTMENT:  word = c.time_adjustment;
            CSR_ADJUST_THRESHOLD: word[DEPTH_W-1:0] = c.adjust_threshold;
            CSR_IDEAL_DPC_RATE:   word[DEPTH_W-1:0] = c.ideal_dpc_rate;
            CSR_DEPTH_CEILING:    word[DEPTH_W-1:0] = c.depth_ceiling;
            CSR_QUANTUM_STEP:     word[STEP_W-1:0] = c.quantum_step;
            default: ;
         endcase
         write_csr(idx, word);
         idx = idx.next();
      end
      // indexes past the last register must be ignored
      if (unused_too) begin
         for (int k = int'(CSR_QUANTUM_STEP) + 1; k < 2 ** CSR_IDX_W; k++) begin
            write_csr(k[CSR_IDX_W-1:0], CSR_DATA_W'($urandom));
         end
      end
      csr_chan.valid <= 1'b0;
      active_cfg = c;
   endtask

   // wait until every result is back, then let the pipeline settle
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result channel pacing, with a long hold-off on request
   initial begin : result_pacing
      int span;
      int holds_served;
      holds_served = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests > holds_served) begin
            holds_served++;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            span = pick_gap();
            if (span == 0) begin
               rsp_chan.ready <= 1'b1;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end else begin
               rsp_chan.ready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("simulation failed");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      cfg_type setting;
      steady        = 1'b0;
      big_steps     = 1'b0;
      hold_requests = 0;
      dpc_running   = '0;
      active_cfg    = '{RST_MAX_INCREMENT, RST_TIME_ADJUSTMENT, RST_ADJUST_THRESHOLD,
                        RST_IDEAL_DPC_RATE, RST_DEPTH_CEILING, RST_QUANTUM_STEP};
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.skip_tick      <= 1'b0;
      req_chan.increment      <= '0;
      req_chan.old_level      <= '0;
      req_chan.dpc_active     <= 1'b0;
      req_chan.dpc_total      <= '0;
      req_chan.queue_depth    <= '0;
      req_chan.thread_quantum <= '0;
      req_chan.is_idle        <= 1'b0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= '0;
      csr_chan.data           <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: skipped, partial, exact zero offset, level split, saturations
      offer_tick(make_tick(1, 24'hFFFFFF, 5'd31, 1, 32'hFFFFFFFF, 8'hFF, 8'shFF, 1));
      offer_tick(make_tick(0, 24'd0, 5'd0, 0, 32'd0, 8'd0, 8'sd0, 0));
      offer_tick(make_tick(0, 24'd99999, 5'd1, 0, 32'd10, 8'd0, 8'sd5, 0));
      offer_tick(make_tick(0, 24'd1, 5'd0, 0, 32'd12, 8'd0, 8'sd5, 0));
      offer_tick(make_tick(0, 24'd100000, 5'd3, 0, 32'd40, 8'd7, 8'sd3, 0));
      offer_tick(make_tick(0, 24'd100000, 5'd2, 1, 32'd45, 8'd9, 8'sh81, 1));
      offer_tick(make_tick(0, 24'd100000, 5'd2, 0, 32'd45, 8'd0, 8'sh80, 0));
      offer_tick(make_tick(0, 24'hFFFFFF, 5'd31, 1, 32'hFFFFFFFF, 8'd3, 8'sh7F, 0));
      offer_tick(make_tick(0, 24'hFFFFFF, 5'd1, 1, 32'd0, 8'hFF, 8'sh80, 1));
      offer_tick(make_tick(1, 24'd0, 5'd0, 0, 32'd0, 8'd0, 8'sd0, 0));
      offer_tick(make_tick(0, 24'd100000, 5'd2, 1, 32'd5, 8'hFF, 8'sd1, 0));
      offer_tick(make_tick(0, 24'd0, 5'd2, 0, 32'd5, 8'd1, 8'sd0, 1));
      offer_tick(make_tick(0, 24'd12345, 5'd4, 0, 32'd6, 8'd0, 8'sd3, 1));

      // random ticks over several register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            setting = CFG_BITS'({$urandom, $urandom, $urandom});
            setting.max_increment = INC_W'($urandom_range(1, 5000));
            case (phase)
               1: setting = '{24'd1, 24'd0, 8'd1, 8'd0, 8'd1, 4'd1};
               2: setting = '{24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 4'hF};
               3: setting = '{24'd300, 24'd1000, 8'd3, 8'd30, 8'd8, 4'd2};
               6: setting = '{24'd0, setting.time_adjustment, 8'd0, 8'hFF, 8'd0, 4'd0};
               7: setting.max_increment = 24'hFFFFFF;
               default: ;
            endcase
            program_settings(setting, phase == 6);
         end
         steady = (phase == 3 || phase == 5);
         // large steps with no reload push the offset to its floor
         big_steps = (phase == 6);
         if (phase == 3) begin
            hold_requests++;
         end
         repeat (TICKS_PER_PHASE) offer_tick(random_tick());
         req_chan.valid <= 1'b0;
      end

      wait_drained();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
